// ----- rtl/tolbf_pkg.sv -----
`default_nettype none

package tolbf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 17;
    localparam int PROD_W   = SAMPLE_W + COEF_W + 1;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 16;
    localparam int WIDE_W   = ACC_W - FRAC_W;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [WIDE_W-1:0]   t_wide;

    // one sample moving along the row of cells
    typedef struct packed {
        logic    vld;
        t_sample smp;
    } t_tok;

    typedef struct packed {
        t_coef gain;
        t_coef decay;
    } t_pole;

    localparam logic [1:0] REG_LP_GAIN  = 2'd0;
    localparam logic [1:0] REG_LP_DECAY = 2'd1;
    localparam logic [1:0] REG_HP_GAIN  = 2'd2;
    localparam logic [1:0] REG_HP_DECAY = 2'd3;

    localparam t_coef RST_LP_GAIN  = 17'd22794;
    localparam t_coef RST_LP_DECAY = 17'd42742;
    localparam t_coef RST_HP_GAIN  = 17'd927;
    localparam t_coef RST_HP_DECAY = 17'd64609;

    localparam t_acc  ROUND_HALF = t_acc'(32768);
    localparam t_wide WIDE_MAX   = t_wide'(8388607);
    localparam t_wide WIDE_MIN   = -t_wide'(8388608);

    function automatic t_sample sat24(input t_wide v);
        t_sample r;
        if (v > WIDE_MAX) begin
            r = t_sample'(WIDE_MAX);
        end else if (v < WIDE_MIN) begin
            r = t_sample'(WIDE_MIN);
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tolbf_cell.sv -----
`default_nettype none

module tolbf_cell import tolbf_pkg::*; #(
    parameter bit HIGH_PASS = 1'b0
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_pole i_coef,
    input  t_tok  i_tok,
    output t_tok  o_tok
);

    logic    r_mvld;
    logic    r_ovld;
    t_sample r_y;
    t_sample r_s;
    t_sample r_osmp;
    t_prod   r_pg;
    t_prod   r_pd;

    t_acc    w_acc;
    t_wide   w_q;
    t_sample w_y;
    t_wide   w_diff;
    t_sample n_smp;

    always_comb begin
        w_acc  = {{2{r_pg[PROD_W-1]}}, r_pg} + {{2{r_pd[PROD_W-1]}}, r_pd} + ROUND_HALF;
        // arithmetic shift floors, so the half bias gives round half up
        w_q    = w_acc[ACC_W-1:FRAC_W];
        w_y    = sat24(w_q);
        w_diff = {{(WIDE_W-SAMPLE_W){r_s[SAMPLE_W-1]}}, r_s}
               - {{(WIDE_W-SAMPLE_W){w_y[SAMPLE_W-1]}}, w_y};
        n_smp  = HIGH_PASS ? sat24(w_diff) : w_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
            r_ovld <= 1'b0;
            r_y    <= '0;
        end else begin
            r_mvld <= i_tok.vld;
            r_ovld <= r_mvld;
            if (r_mvld) begin
                r_y <= w_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_pg <= $signed({1'b0, i_coef.gain}) * $signed(i_tok.smp);
            r_pd <= $signed({1'b0, i_coef.decay}) * r_y;
            r_s  <= i_tok.smp;
        end
        if (r_mvld) begin
            r_osmp <= n_smp;
        end
    end

    assign o_tok.vld = r_ovld;
    assign o_tok.smp = r_osmp;

endmodule

`default_nettype wire

// ----- rtl/third_order_band_limit_filter_top.sv -----
// channel      | dir | signals                              | payload
// s_axis       | in  | tvalid / tready / tdata[23:0]        | sample_in, signed Q1.23
// m_axis       | out | tvalid / tready / tdata[23:0]        | sample_out, signed Q1.23
// apb          | in  | psel penable pwrite paddr[3:0] pwdata | coefficient registers
//
// a sample walks a row of 2*STAGES_PER_SECTION cells, each registering the products
// (multiply) and then the result (add, round, saturate), before the output register
// one sample is in the row at a time; s_axis_tready drops from accept until the
// result is in the output register; a result finding the output full waits in a hold
// register; synchronous reset clears all stage states and loads default coefficients
`default_nettype none

module third_order_band_limit_filter_top import tolbf_pkg::*; #(
    parameter int STAGES_PER_SECTION = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire  [SAMPLE_W-1:0]   i_s_axis_tdata,   // [23:0] sample_in
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [SAMPLE_W-1:0]   o_m_axis_tdata,   // [23:0] sample_out
    input  wire                   i_psel,
    input  wire                   i_penable,
    input  wire                   i_pwrite,
    input  wire  [APB_ADDR_W-1:0] i_paddr,
    input  wire  [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int NCELLS = 2 * STAGES_PER_SECTION;

    t_coef   r_lp_gain;
    t_coef   r_lp_decay;
    t_coef   r_hp_gain;
    t_coef   r_hp_decay;

    logic    r_busy;
    logic    r_out_vld;
    logic    r_hold_vld;
    t_sample r_out;
    t_sample r_hold;

    t_tok    w_tok [0:NCELLS];
    logic    [NCELLS-1:0] w_cell_vld;
    t_pole   w_hp;
    t_pole   w_lp;
    logic    w_accept;
    logic    w_done;
    logic    w_out_free;
    logic    w_wr;

    // ---- configuration
    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_gain  <= RST_LP_GAIN;
            r_lp_decay <= RST_LP_DECAY;
            r_hp_gain  <= RST_HP_GAIN;
            r_hp_decay <= RST_HP_DECAY;
        end else if (w_wr) begin
            case (i_paddr[3:2])
                REG_LP_GAIN:  r_lp_gain  <= i_pwdata[COEF_W-1:0];
                REG_LP_DECAY: r_lp_decay <= i_pwdata[COEF_W-1:0];
                REG_HP_GAIN:  r_hp_gain  <= i_pwdata[COEF_W-1:0];
                REG_HP_DECAY: r_hp_decay <= i_pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_LP_GAIN:  o_prdata = {{(APB_DATA_W-COEF_W){1'b0}}, r_lp_gain};
            REG_LP_DECAY: o_prdata = {{(APB_DATA_W-COEF_W){1'b0}}, r_lp_decay};
            REG_HP_GAIN:  o_prdata = {{(APB_DATA_W-COEF_W){1'b0}}, r_hp_gain};
            REG_HP_DECAY: o_prdata = {{(APB_DATA_W-COEF_W){1'b0}}, r_hp_decay};
            default:      o_prdata = '0;
        endcase
    end

    // ---- row of cells
    assign w_hp.gain  = r_hp_gain;
    assign w_hp.decay = r_hp_decay;
    assign w_lp.gain  = r_lp_gain;
    assign w_lp.decay = r_lp_decay;

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;
    assign w_tok[0].vld    = w_accept;
    assign w_tok[0].smp    = i_s_axis_tdata;

    genvar gi;
    generate
        for (gi = 0; gi < NCELLS; gi++) begin : g_cell
            if (gi < STAGES_PER_SECTION) begin : g_hp
                tolbf_cell #(.HIGH_PASS(1'b1)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_coef  (w_hp),
                    .i_tok   (w_tok[gi]),
                    .o_tok   (w_tok[gi+1])
                );
            end else begin : g_lp
                tolbf_cell #(.HIGH_PASS(1'b0)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_coef  (w_lp),
                    .i_tok   (w_tok[gi]),
                    .o_tok   (w_tok[gi+1])
                );
            end
            assign w_cell_vld[gi] = w_tok[gi+1].vld;
        end
    endgenerate

    // ---- output register and hold
    assign w_done     = w_tok[NCELLS].vld;
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if ((w_done || r_hold_vld) && w_out_free) begin
                r_busy <= 1'b0;
            end
            if (w_out_free) begin
                r_out_vld <= w_done || r_hold_vld;
            end
            if (w_done && !w_out_free) begin
                r_hold_vld <= 1'b1;
            end else if (w_out_free) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && !w_out_free) begin
            r_hold <= w_tok[NCELLS].smp;
        end
        if (w_out_free) begin
            r_out <= r_hold_vld ? r_hold : w_tok[NCELLS].smp;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    // ---- checks
    a_one_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cell_vld))
        else $error("more than one sample in the cell row");

    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> r_out_vld)
        else $error("hold register full while output register empty");

    a_no_done_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_done && r_hold_vld))
        else $error("row finished while a result still waits in hold");

    a_busy_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_cell_vld) |-> r_busy)
        else $error("sample in the row while input is open");

endmodule

`default_nettype wire

// ----- tb/band_filter_checker.sv -----
`timescale 1ns / 100ps

module band_filter_checker import tolbf_pkg::*; #(
    parameter int STAGES_PER_SECTION = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    input  wire                   i_s_tready,
    input  wire  [SAMPLE_W-1:0]   i_s_tdata,    // [23:0] sample_in
    input  wire                   i_m_tvalid,
    input  wire                   i_m_tready,
    input  wire  [SAMPLE_W-1:0]   i_m_tdata,    // [23:0] sample_out
    input  wire                   i_psel,
    input  wire                   i_penable,
    input  wire                   i_pwrite,
    input  wire  [APB_ADDR_W-1:0] i_paddr,
    input  wire  [APB_DATA_W-1:0] i_pwdata,
    input  wire  [APB_DATA_W-1:0] i_prdata,
    input  wire                   i_pready,
    output int                    o_pending,
    output int                    o_failures,
    output int                    o_compared
);

    localparam longint CLIP_HI = 64'sd8388607;
    localparam longint CLIP_LO = -64'sd8388608;

    t_coef   coef_reg [4];
    t_sample hp_state [STAGES_PER_SECTION];
    t_sample lp_state [STAGES_PER_SECTION];
    t_sample expected_samples [$];
    int      fail_count = 0;
    int      compare_count = 0;

    function automatic t_sample clip24(input longint v);
        t_sample r;
        if (v > CLIP_HI) begin
            r = t_sample'(CLIP_HI);
        end else if (v < CLIP_LO) begin
            r = t_sample'(CLIP_LO);
        end else begin
            r = t_sample'(v);
        end
        return r;
    endfunction

    // g*x + d*prev in Q16, rounded half up by the bias and the flooring shift
    function automatic t_sample one_pole(input t_coef g, input t_coef d,
                                         input t_sample x, input t_sample prev);
        longint acc;
        acc = longint'(g) * longint'(x) + longint'(d) * longint'(prev) + 64'sd32768;
        return clip24(acc >>> FRAC_W);
    endfunction

    // advances the stage states by one sample and returns the filtered sample
    function automatic t_sample filter_sample(input t_sample x);
        t_sample s;
        t_sample y;
        s = x;
        for (int i = 0; i < STAGES_PER_SECTION; i++) begin
            y = one_pole(coef_reg[REG_HP_GAIN], coef_reg[REG_HP_DECAY], s, hp_state[i]);
            hp_state[i] = y;
            s = clip24(longint'(s) - longint'(y));
        end
        for (int i = 0; i < STAGES_PER_SECTION; i++) begin
            y = one_pole(coef_reg[REG_LP_GAIN], coef_reg[REG_LP_DECAY], s, lp_state[i]);
            lp_state[i] = y;
            s = y;
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_sample want;
        logic [APB_DATA_W-1:0] reg_value;
        if (!i_rst_n) begin
            coef_reg[REG_LP_GAIN]  = RST_LP_GAIN;
            coef_reg[REG_LP_DECAY] = RST_LP_DECAY;
            coef_reg[REG_HP_GAIN]  = RST_HP_GAIN;
            coef_reg[REG_HP_DECAY] = RST_HP_DECAY;
            for (int i = 0; i < STAGES_PER_SECTION; i++) begin
                hp_state[i] = '0;
                lp_state[i] = '0;
            end
            expected_samples.delete();
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    coef_reg[i_paddr[3:2]] = i_pwdata[COEF_W-1:0];
                end else begin
                    reg_value = APB_DATA_W'(coef_reg[i_paddr[3:2]]);
                    if (i_prdata !== reg_value) begin
                        fail_count++;
                        $display("%0t: register read at 0x%0h, expected %0d, actual %0d",
                                 $time, i_paddr, reg_value, i_prdata);
                    end
                end
            end
            // result side first: an output transaction always belongs to an earlier sample
            if (i_m_tvalid && i_m_tready) begin
                if (expected_samples.size() == 0) begin
                    fail_count++;
                    $display("%0t: sample_out %0d arrived with nothing expected",
                             $time, $signed(i_m_tdata));
                end else begin
                    want = expected_samples.pop_front();
                    compare_count++;
                    if (i_m_tdata !== want) begin
                        fail_count++;
                        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                                 $time, want, $signed(i_m_tdata));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_samples.push_back(filter_sample(t_sample'(i_s_tdata)));
            end
        end
        o_pending  <= expected_samples.size();
        o_failures <= fail_count;
        o_compared <= compare_count;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb import tolbf_pkg::*;;

    localparam int      TIMEOUT_CYCLES = 400000;
    localparam t_sample SMP_TOP        = 24'sh7FFFFF;
    localparam t_sample SMP_BOTTOM     = 24'sh800000;
    localparam t_coef   COEF_UNITY     = 17'd65536;
    localparam t_coef   COEF_FULL      = 17'd131071;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int failures;
    int compared;
    int samples_sent = 0;
    int coef_sets = 0;
    int cycle_count = 0;
    bit calm = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    third_order_band_limit_filter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    band_filter_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_pending  (pending),
        .o_failures (failures),
        .o_compared (compared)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // output backpressure in random bursts, none once the run is calm
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // junk in the unused upper bits now and then; the register keeps 17 bits
    task automatic write_coef(input logic [1:0] idx, input t_coef value);
        logic [APB_DATA_W-COEF_W-1:0] upper;
        upper = $urandom_range(0, 1) ? (APB_DATA_W-COEF_W)'($urandom) : '0;
        apb_access(1'b1, idx, {upper, value});
    endtask

    task automatic read_all_coefs();
        apb_access(1'b0, REG_LP_GAIN, '0);
        apb_access(1'b0, REG_LP_DECAY, '0);
        apb_access(1'b0, REG_HP_GAIN, '0);
        apb_access(1'b0, REG_HP_DECAY, '0);
    endtask

    task automatic send_sample(input t_sample x);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge i_clk); while (!s_tready);
        samples_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // hold the input until every outstanding result is out, then let the row settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4 * 3 + 8) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = t_sample'($urandom);
            4:          v = SMP_TOP;
            5:          v = SMP_BOTTOM;
            6, 7:       v = t_sample'(int'($urandom_range(0, 4000)) - 2000);
            default: begin
                if ($urandom_range(0, 1)) begin
                    v = SMP_TOP - t_sample'($urandom_range(0, 65535));
                end else begin
                    v = SMP_BOTTOM + t_sample'($urandom_range(0, 65535));
                end
            end
        endcase
        return v;
    endfunction

    function automatic t_coef rand_coef();
        t_coef c;
        case ($urandom_range(0, 7))
            0:       c = '0;
            1:       c = COEF_UNITY;
            2:       c = COEF_FULL;
            3:       c = t_coef'($urandom);
            4:       c = t_coef'($urandom_range(60000, 65536));
            default: c = t_coef'($urandom_range(0, 65536));
        endcase
        return c;
    endfunction

    task automatic run_set(input t_coef lp_g, input t_coef lp_d, input t_coef hp_g,
                           input t_coef hp_d, input int count);
        drain();
        write_coef(REG_LP_GAIN, lp_g);
        write_coef(REG_LP_DECAY, lp_d);
        write_coef(REG_HP_GAIN, hp_g);
        write_coef(REG_HP_DECAY, hp_d);
        read_all_coefs();
        coef_sets++;
        send_sample(SMP_TOP);
        send_sample(SMP_BOTTOM);
        repeat (count) send_sample(rand_sample());
    endtask

    initial begin
        t_sample directed [$];
        directed = '{SMP_TOP, SMP_BOTTOM, 24'sd0, -24'sd1, 24'sd1,
                     24'sh555555, 24'shAAAAAA};
        repeat (6) directed.push_back(SMP_TOP);
        repeat (6) directed.push_back(SMP_BOTTOM);
        directed.push_back(24'sd0);
        directed.push_back(24'sd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients first, with read-back of their reset values
        read_all_coefs();
        coef_sets++;
        foreach (directed[i]) send_sample(directed[i]);

        run_set('0, '0, '0, '0, 38);
        run_set(COEF_UNITY, COEF_UNITY, COEF_UNITY, COEF_UNITY, 38);
        run_set(COEF_FULL, COEF_FULL, COEF_FULL, COEF_FULL, 38);
        // unity low-pass with no high-pass removal passes the sample straight through
        run_set(COEF_UNITY, '0, '0, '0, 38);
        run_set('0, COEF_FULL, COEF_FULL, '0, 38);
        run_set(rand_coef(), rand_coef(), rand_coef(), rand_coef(), 70);
        run_set(rand_coef(), rand_coef(), rand_coef(), rand_coef(), 70);
        drain();
        calm = 1'b1;
        run_set(RST_LP_GAIN, RST_LP_DECAY, RST_HP_GAIN, t_coef'($urandom_range(60000, 65536)),
                70);
        drain();

        $display("run covered %0d samples under %0d coefficient sets (zero, unity, full scale",
                 samples_sent, coef_sets);
        $display("and random) with saturating inputs; %0d results compared", compared);
        if (failures == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
